### rtl/core/lcl_pkg.sv
// Shared types and constants for the lattice cell locator.
// Used by the axis lanes, the index merge, the corner emitter and the top level.
// No dependencies.
package lcl_pkg;

    // Fixed field widths
    localparam int POS_W   = 32;
    localparam int INV_W   = 32;
    localparam int GRID_W  = 9;
    localparam int HALO_W  = 3;
    localparam int IDX_W   = 25;
    localparam int FRAC_W  = 16;
    localparam int REST_W  = 17;
    localparam int HX_W    = 9;
    localparam int HXHY_W  = 17;
    localparam int PROD_W  = 64;
    localparam int REL_W   = 50;
    localparam int IND_W   = REL_W - FRAC_W;

    // Limits and tolerance (tolerance in Q.16 LSBs)
    localparam logic [GRID_W-1:0] MAX_GRID  = 9'd256;
    localparam logic [HALO_W-1:0] MAX_HALO  = 3'd4;
    localparam int                TOLERANCE = 1;

    localparam logic [REST_W-1:0] ONE_Q16  = 17'd65536;
    localparam logic [FRAC_W-1:0] HALF_Q16 = 16'h8000;
    localparam logic [FRAC_W-1:0] FRAC_MAX = 16'hFFFF;

    // Configuration register indexes
    localparam logic [2:0] REG_INV_SPACING = 3'd0;
    localparam logic [2:0] REG_ORIGIN_X    = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Y    = 3'd2;
    localparam logic [2:0] REG_ORIGIN_Z    = 3'd3;
    localparam logic [2:0] REG_GRID_X      = 3'd4;
    localparam logic [2:0] REG_GRID_Y      = 3'd5;
    localparam logic [2:0] REG_GRID_Z      = 3'd6;
    localparam logic [2:0] REG_HALO_SIZE   = 3'd7;

    // Stream widths
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 128;
    localparam int M_TUSER_W = 4;

    // Stage load enables for the axis lanes
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } lane_en_t;

    // Stage load enables for the index merge
    typedef struct packed {
        logic s5;
        logic s6;
    } merge_en_t;

    // Per-axis lane result
    typedef struct packed {
        logic [GRID_W-1:0] ind;
        logic [FRAC_W-1:0] frac;
        logic [REST_W-1:0] rest;
        logic              err;
    } lane_res_t;

    // One located particle, ready for corner expansion
    typedef struct packed {
        logic [IDX_W-1:0]  base;
        logic [FRAC_W-1:0] frac_x;
        logic [FRAC_W-1:0] frac_y;
        logic [FRAC_W-1:0] frac_z;
        logic [REST_W-1:0] rest_x;
        logic [REST_W-1:0] rest_y;
        logic [REST_W-1:0] rest_z;
        logic              err;
    } cell_item_t;

endpackage

### rtl/core/lcl_axis_lane.sv
// One axis lane: offset, scale by reciprocal spacing, floor, clamp.
// Four register stages; loads are driven by the top-level pipeline control.
// Depends on lcl_pkg.
module lcl_axis_lane (
    input  logic                      clk,
    input  lcl_pkg::lane_en_t         en,
    input  logic [lcl_pkg::POS_W-1:0] pos,
    input  logic [lcl_pkg::POS_W-1:0] origin,
    input  logic [lcl_pkg::INV_W-1:0] inv_spacing,
    input  logic [lcl_pkg::GRID_W-1:0] grid,
    output lcl_pkg::lane_res_t        res
);
    import lcl_pkg::*;

    logic signed [POS_W:0]   lpos;
    logic                    neg1_reg;
    logic [POS_W-1:0]        mag_reg;
    logic                    neg2_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [REL_W-1:0]        q_ext;
    logic [REL_W-1:0]        q_sel;
    logic                    rnd;
    logic [REL_W-1:0]        rel_next;
    logic signed [REL_W-1:0] rel_reg;
    logic signed [IND_W-1:0] ind;
    logic [REL_W-1:0]        hi_limit;
    logic                    low_ok;
    logic                    hi_ok;
    lane_res_t               res_next;
    lane_res_t               res_reg;

    // Stage 1: local position, sign and magnitude
    assign lpos = $signed({pos[POS_W-1], pos}) - $signed({origin[POS_W-1], origin});

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            neg1_reg <= lpos[POS_W];
            mag_reg  <= lpos[POS_W] ? POS_W'(-lpos) : lpos[POS_W-1:0];
        end
    end

    // Stage 2: magnitude times reciprocal spacing
    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            neg2_reg <= neg1_reg;
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(inv_spacing);
        end
    end

    // Stage 3: signed Q.16 value rounded toward minus infinity, plus one half
    assign q_ext    = REL_W'(prod_reg[PROD_W-1:FRAC_W]);
    assign rnd      = |prod_reg[FRAC_W-1:0];
    assign q_sel    = neg2_reg ? ~q_ext : q_ext;
    assign rel_next = q_sel + REL_W'(neg2_reg & ~rnd) + REL_W'(HALF_Q16);

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            rel_reg <= $signed(rel_next);
        end
    end

    // Stage 4: floor to a cell index and clamp against 0..grid
    assign ind      = rel_reg[REL_W-1:FRAC_W];
    assign hi_limit = {25'd0, grid, HALF_Q16} + REL_W'(TOLERANCE * int'(grid));
    assign low_ok   = $signed(rel_reg + REL_W'(TOLERANCE)) > $signed(REL_W'(0));
    assign hi_ok    = rel_reg < hi_limit;

    always_comb
    begin
        res_next.ind  = ind[GRID_W-1:0];
        res_next.frac = rel_reg[FRAC_W-1:0];
        res_next.err  = 1'b0;
        if (rel_reg[REL_W-1])
        begin
            // below the first cell
            res_next.ind = '0;
            if (low_ok)
                res_next.frac = '0;
            else
                res_next.err = 1'b1;
        end
        else if (ind > $signed({{(IND_W-GRID_W){1'b0}}, grid}))
        begin
            // beyond the last node
            res_next.ind = grid;
            if (hi_ok)
                res_next.frac = FRAC_MAX;
            else
                res_next.err = 1'b1;
        end
        res_next.rest = ONE_Q16 - REST_W'(res_next.frac);
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

### rtl/core/lcl_index_merge.sv
// Merges the three lane results into one linear base node index.
// Two register stages: products by the halo strides, then the sum.
// Depends on lcl_pkg.
module lcl_index_merge (
    input  logic                        clk,
    input  lcl_pkg::merge_en_t          en,
    input  lcl_pkg::lane_res_t          lane_x,
    input  lcl_pkg::lane_res_t          lane_y,
    input  lcl_pkg::lane_res_t          lane_z,
    input  logic [lcl_pkg::HX_W-1:0]    hx,
    input  logic [lcl_pkg::HXHY_W-1:0]  hxhy,
    output lcl_pkg::cell_item_t         item
);
    import lcl_pkg::*;

    logic [GRID_W-1:0]        ind_x_reg;
    logic [GRID_W+HX_W-1:0]   prod_y_reg;
    logic [GRID_W+HXHY_W-1:0] prod_z_reg;
    cell_item_t               w5_reg;
    cell_item_t               item_next;
    cell_item_t               item_reg;

    // Stage 5: stride products, weights and error carried along
    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            ind_x_reg      <= lane_x.ind;
            prod_y_reg     <= (GRID_W+HX_W)'(lane_y.ind) * (GRID_W+HX_W)'(hx);
            prod_z_reg     <= (GRID_W+HXHY_W)'(lane_z.ind) * (GRID_W+HXHY_W)'(hxhy);
            w5_reg.base    <= '0;
            w5_reg.frac_x  <= lane_x.frac;
            w5_reg.frac_y  <= lane_y.frac;
            w5_reg.frac_z  <= lane_z.frac;
            w5_reg.rest_x  <= lane_x.rest;
            w5_reg.rest_y  <= lane_y.rest;
            w5_reg.rest_z  <= lane_z.rest;
            w5_reg.err     <= lane_x.err | lane_y.err | lane_z.err;
        end
    end

    // Base index, wrapped to the index width
    always_comb
    begin
        item_next      = w5_reg;
        item_next.base = IDX_W'(ind_x_reg) + IDX_W'(prod_y_reg) + prod_z_reg[IDX_W-1:0];
    end

    // Stage 6
    always_ff @(posedge clk)
    begin
        if (en.s6)
        begin
            item_reg <= item_next;
        end
    end

    assign item = item_reg;

endmodule

### rtl/core/lcl_corner_emit.sv
// Expands one located particle into eight corners, one per cycle unless stalled.
// Holds one particle while the output register drains; depends on lcl_pkg.
module lcl_corner_emit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  lcl_pkg::cell_item_t          in_item,
    input  logic [lcl_pkg::HX_W-1:0]     hx,
    input  logic [lcl_pkg::HXHY_W-1:0]   hxhy,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [lcl_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [lcl_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                         m_tlast
);
    import lcl_pkg::*;

    logic                   hold_valid_reg;
    logic                   hold_valid_next;
    cell_item_t             hold_reg;
    logic [2:0]             cnt_reg;
    logic [2:0]             cnt_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [M_TDATA_W-1:0]   data_reg;
    logic [M_TUSER_W-1:0]   user_reg;
    logic                   last_reg;
    logic                   load_out;
    logic                   hold_done;
    logic [IDX_W-1:0]       node_idx;

    // Output register takes the next corner when empty or being drained
    assign load_out  = hold_valid_reg && (!out_valid_reg || m_tready);
    assign hold_done = load_out && (cnt_reg == 3'd7);
    assign in_ready  = !hold_valid_reg || hold_done;

    // Corner node: base plus one step along each axis selected by the corner bits
    assign node_idx = hold_reg.base + IDX_W'(cnt_reg[0])
                    + (cnt_reg[1] ? IDX_W'(hx) : '0)
                    + (cnt_reg[2] ? IDX_W'(hxhy) : '0);

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        if (m_tready)
            out_valid_next = 1'b0;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            cnt_next       = cnt_reg + 3'd1;
        end
        if (hold_done)
            hold_valid_next = 1'b0;
        if (in_valid && in_ready)
            hold_valid_next = 1'b1;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Held particle
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            hold_reg <= in_item;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            data_reg <= {4'd0, hold_reg.rest_z, hold_reg.rest_y, hold_reg.rest_x,
                         hold_reg.frac_z, hold_reg.frac_y, hold_reg.frac_x, node_idx};
            user_reg <= {hold_reg.err, cnt_reg};
            last_reg <= (cnt_reg == 3'd7);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

### rtl/core/lattice_cell_locator.sv
// Lattice cell locator: three axis lanes, index merge and corner emitter.
// Path from input accept to the first corner result: 6 pipeline stages, the hold
// register and the output register; the other seven corners come from the same hold.
// Throughput is set by the single corner output channel: eight results per position.
// Reset (rst_n, async, active low) clears pipeline valids and restores the
// configuration registers to their defaults. Depends on lcl_pkg and the submodules.
module lattice_cell_locator (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [2:0]                     cfg_index,
    input  logic [31:0]                    cfg_data,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata: position_x[31:0], position_y[63:32], position_z[95:64]
    input  logic [lcl_pkg::S_TDATA_W-1:0]  s_tdata,
    // output stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: node_addr[24:0], frac_x[40:25], frac_y[56:41], frac_z[72:57],
    //          rest_x[89:73], rest_y[106:90], rest_z[123:107], zero[127:124]
    output logic [lcl_pkg::M_TDATA_W-1:0]  m_tdata,
    // m_tuser: corner[2:0], out_of_range[3]
    output logic [lcl_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                           m_tlast
);
    import lcl_pkg::*;

    logic [INV_W-1:0]  inv_spacing_reg;
    logic [POS_W-1:0]  origin_x_reg;
    logic [POS_W-1:0]  origin_y_reg;
    logic [POS_W-1:0]  origin_z_reg;
    logic [GRID_W-1:0] grid_x_reg;
    logic [GRID_W-1:0] grid_y_reg;
    logic [GRID_W-1:0] grid_z_reg;
    logic [HALO_W-1:0] halo_reg;
    logic [HXHY_W-1:0] hxhy_reg;

    logic [GRID_W-1:0] g_x;
    logic [GRID_W-1:0] g_y;
    logic [GRID_W-1:0] g_z;
    logic [HALO_W-1:0] halo;
    logic [HX_W-1:0]   hx;
    logic [HX_W-1:0]   hy;

    logic [6:1]        v_reg;
    logic [6:1]        v_next;
    logic [6:1]        rdy;
    logic              emit_ready;
    lane_en_t          lane_en;
    merge_en_t         merge_en;
    lane_res_t         res_x;
    lane_res_t         res_y;
    lane_res_t         res_z;
    cell_item_t        item;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_spacing_reg <= 32'd65536;
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            origin_z_reg    <= '0;
            grid_x_reg      <= 9'd16;
            grid_y_reg      <= 9'd16;
            grid_z_reg      <= 9'd16;
            halo_reg        <= 3'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INV_SPACING: inv_spacing_reg <= cfg_data;
                REG_ORIGIN_X:    origin_x_reg    <= cfg_data;
                REG_ORIGIN_Y:    origin_y_reg    <= cfg_data;
                REG_ORIGIN_Z:    origin_z_reg    <= cfg_data;
                REG_GRID_X:      grid_x_reg      <= cfg_data[GRID_W-1:0];
                REG_GRID_Y:      grid_y_reg      <= cfg_data[GRID_W-1:0];
                REG_GRID_Z:      grid_z_reg      <= cfg_data[GRID_W-1:0];
                REG_HALO_SIZE:   halo_reg        <= cfg_data[HALO_W-1:0];
                default:         ;
            endcase
        end
    end

    // Saturated grid and halo, halo-grid strides
    assign g_x  = (grid_x_reg > MAX_GRID) ? MAX_GRID : grid_x_reg;
    assign g_y  = (grid_y_reg > MAX_GRID) ? MAX_GRID : grid_y_reg;
    assign g_z  = (grid_z_reg > MAX_GRID) ? MAX_GRID : grid_z_reg;
    assign halo = (halo_reg > MAX_HALO) ? MAX_HALO : halo_reg;
    assign hx   = g_x + HX_W'({halo, 1'b0});
    assign hy   = g_y + HX_W'({halo, 1'b0});

    always_ff @(posedge clk)
    begin
        hxhy_reg <= HXHY_W'(hx) * HXHY_W'(hy);
    end

    // Pipeline control: a stage loads when empty or when it passes its item on
    assign rdy[6] = !v_reg[6] || emit_ready;
    assign rdy[5] = !v_reg[5] || rdy[6];
    assign rdy[4] = !v_reg[4] || rdy[5];
    assign rdy[3] = !v_reg[3] || rdy[4];
    assign rdy[2] = !v_reg[2] || rdy[3];
    assign rdy[1] = !v_reg[1] || rdy[2];
    assign s_tready = rdy[1];

    always_comb
    begin
        v_next[1] = rdy[1] ? s_tvalid : v_reg[1];
        for (int i = 2; i <= 6; i++)
            v_next[i] = rdy[i] ? v_reg[i-1] : v_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign lane_en.s1  = rdy[1];
    assign lane_en.s2  = rdy[2];
    assign lane_en.s3  = rdy[3];
    assign lane_en.s4  = rdy[4];
    assign merge_en.s5 = rdy[5];
    assign merge_en.s6 = rdy[6];

    // Axis lanes
    lcl_axis_lane u_lane_x (
        .clk         (clk),
        .en          (lane_en),
        .pos         (s_tdata[31:0]),
        .origin      (origin_x_reg),
        .inv_spacing (inv_spacing_reg),
        .grid        (g_x),
        .res         (res_x)
    );

    lcl_axis_lane u_lane_y (
        .clk         (clk),
        .en          (lane_en),
        .pos         (s_tdata[63:32]),
        .origin      (origin_y_reg),
        .inv_spacing (inv_spacing_reg),
        .grid        (g_y),
        .res         (res_y)
    );

    lcl_axis_lane u_lane_z (
        .clk         (clk),
        .en          (lane_en),
        .pos         (s_tdata[95:64]),
        .origin      (origin_z_reg),
        .inv_spacing (inv_spacing_reg),
        .grid        (g_z),
        .res         (res_z)
    );

    // Base index merge
    lcl_index_merge u_merge (
        .clk    (clk),
        .en     (merge_en),
        .lane_x (res_x),
        .lane_y (res_y),
        .lane_z (res_z),
        .hx     (hx),
        .hxhy   (hxhy_reg),
        .item   (item)
    );

    // Corner expansion and output register
    lcl_corner_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v_reg[6]),
        .in_ready (emit_ready),
        .in_item  (item),
        .hx       (hx),
        .hxhy     (hxhy_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### sim/tb_lattice_cell_locator.sv
// Testbench for lattice_cell_locator: streams particle positions under several
// lattice settings, predicts the eight corner items of each and checks them in order.
// Depends on lcl_pkg and the lattice_cell_locator RTL.
module tb_lattice_cell_locator;
    import lcl_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 66;
    localparam int NUM_PHASES      = 7;
    localparam int HOLD_PHASE      = 5;
    localparam int DRAIN_CYCLES    = 24;
    localparam int LONG_HOLD       = 300;
    localparam int NUM_DIRECTED    = 13;

    // One corner item as seen on the output stream
    typedef struct {
        logic [2:0]        corner;
        logic [IDX_W-1:0]  node_addr;
        logic [FRAC_W-1:0] frac [3];
        logic [REST_W-1:0] rest [3];
        logic              out_of_range;
        logic              last;
    } corner_item_t;

    typedef enum int {RX_STEADY, RX_COIN, RX_EVERY_THIRD, RX_MOSTLY} rx_pattern_t;

    // Lattice placement predictor with its own copy of the registers
    class corner_predictor;
        logic [INV_W-1:0]        inv_spacing;
        logic signed [POS_W-1:0] origin [3];
        logic [GRID_W-1:0]       grid [3];
        logic [HALO_W-1:0]       halo;
        corner_item_t            pending_corners [$];
        string                   axis_name [3];
        int unsigned             failures;
        int unsigned             checked;
        int unsigned             flagged;

        function new();
            inv_spacing = 32'd65536;
            halo        = 3'd1;
            axis_name   = '{"x", "y", "z"};
            failures    = 0;
            checked     = 0;
            flagged     = 0;
            for (int a = 0; a < 3; a++)
            begin
                origin[a] = '0;
                grid[a]   = 9'd16;
            end
        endfunction

        function void write_register(input logic [2:0] index, input logic [31:0] value);
            case (index)
                REG_INV_SPACING: inv_spacing = value;
                REG_ORIGIN_X:    origin[0]   = value;
                REG_ORIGIN_Y:    origin[1]   = value;
                REG_ORIGIN_Z:    origin[2]   = value;
                REG_GRID_X:      grid[0]     = value[GRID_W-1:0];
                REG_GRID_Y:      grid[1]     = value[GRID_W-1:0];
                REG_GRID_Z:      grid[2]     = value[GRID_W-1:0];
                REG_HALO_SIZE:   halo        = value[HALO_W-1:0];
                default:         ;
            endcase
        endfunction

        function logic [GRID_W-1:0] effective_grid(input int a);
            return (grid[a] > MAX_GRID) ? MAX_GRID : grid[a];
        endfunction

        // One axis: scaled, half-shifted position split into cell index and fraction
        function void place_axis(input logic signed [POS_W-1:0] pos, input int a,
                                 output logic [GRID_W-1:0] ind,
                                 output logic [FRAC_W-1:0] frac, inout logic err);
            longint          offset, rel, cell_ind, over, g;
            longint unsigned mag, scaled;
            g      = longint'(effective_grid(a));
            offset = longint'(pos) - longint'(origin[a]);
            mag    = (offset < 0) ? -offset : offset;
            scaled = mag * {32'd0, inv_spacing};
            // negative side rounds toward minus infinity
            if (offset >= 0)
                rel = longint'(scaled >> 16);
            else
                rel = -longint'((scaled >> 16) + (scaled[15:0] != 16'd0));
            rel      = rel + longint'(HALF_Q16);
            cell_ind = rel >>> 16;
            frac     = rel[FRAC_W-1:0];
            if (cell_ind < 0)
            begin
                // low clamp within tolerance, else flagged
                if (-rel < TOLERANCE)
                    frac = '0;
                else
                    err = 1'b1;
                cell_ind = 0;
            end
            else if (cell_ind > g)
            begin
                // high clamp within tolerance, else flagged
                over = rel - longint'(HALF_Q16) - g * longint'(ONE_Q16);
                if (over < TOLERANCE * g)
                    frac = FRAC_MAX;
                else
                    err = 1'b1;
                cell_ind = g;
            end
            ind = cell_ind[GRID_W-1:0];
        endfunction

        // Accepted position: queue its eight corner items
        function void note_position(input logic [POS_W-1:0] px, py, pz);
            logic signed [POS_W-1:0] pos [3];
            logic [GRID_W-1:0]       ind [3];
            logic [FRAC_W-1:0]       frac [3];
            logic                    err;
            longint unsigned         h, hx, hxy, base, node;
            corner_item_t            item;
            pos = '{px, py, pz};
            err = 1'b0;
            for (int a = 0; a < 3; a++)
                place_axis(pos[a], a, ind[a], frac[a], err);
            h    = (halo > MAX_HALO) ? MAX_HALO : halo;
            hx   = effective_grid(0) + 2 * h;
            hxy  = hx * (effective_grid(1) + 2 * h);
            base = ind[0] + ind[1] * hx + ind[2] * hxy;
            for (int k = 0; k < 8; k++)
            begin
                node = base + ((k & 1) != 0 ? 1 : 0) + ((k & 2) != 0 ? hx : 0)
                       + ((k & 4) != 0 ? hxy : 0);
                item.corner    = k[2:0];
                item.node_addr = node[IDX_W-1:0];
                for (int a = 0; a < 3; a++)
                begin
                    item.frac[a] = frac[a];
                    item.rest[a] = ONE_Q16 - frac[a];
                end
                item.out_of_range = err;
                item.last         = (k == 7);
                pending_corners.push_back(item);
            end
        endfunction

        function void match(input string name, input longint unsigned want, got);
            if (want != got)
            begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        // Output item: compare against the oldest expectation
        function void check_corner(input corner_item_t got);
            corner_item_t want;
            checked++;
            if (got.out_of_range)
                flagged++;
            if (pending_corners.size() == 0)
            begin
                $error("corner item with none expected: corner %0d node_addr %0d",
                       got.corner, got.node_addr);
                failures++;
                return;
            end
            want = pending_corners.pop_front();
            match("corner", want.corner, got.corner);
            match("node_addr", want.node_addr, got.node_addr);
            for (int a = 0; a < 3; a++)
            begin
                match({"frac_", axis_name[a]}, want.frac[a], got.frac[a]);
                match({"rest_", axis_name[a]}, want.rest[a], got.rest[a]);
            end
            match("out_of_range", want.out_of_range, got.out_of_range);
            match("last", want.last, got.last);
        endfunction
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [2:0]             cfg_index = REG_INV_SPACING;
    logic [31:0]            cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   m_tlast;

    logic                   hold_request = 1'b0;
    logic                   hold_done    = 1'b0;
    int unsigned            hold_left    = 0;
    rx_pattern_t            rx_mode      = RX_STEADY;
    int unsigned            rx_mode_left = 0;
    int unsigned            rx_step      = 0;
    int unsigned            cycle_count  = 0;
    int unsigned            positions_sent = 0;
    int unsigned            burst_left   = 0;
    corner_item_t           seen_corner;
    corner_predictor        corner_model = new();

    // Hand-picked positions under the reset lattice (1.0 spacing, grid 16)
    logic [POS_W-1:0] directed_positions [NUM_DIRECTED][3] = '{
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
        '{32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000},
        '{32'hFFFF_7FFF, 32'h0000_0000, 32'h0000_0000},
        '{32'h0010_7FFF, 32'h0010_7FFF, 32'h0010_7FFF},
        '{32'h0010_8000, 32'h0000_0000, 32'h0000_0000},
        '{32'h0000_0000, 32'h0010_8000, 32'h0000_0000},
        '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_7FFF},
        '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000},
        '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF},
        '{32'hFFFF_FFFF, 32'h0000_7FFF, 32'h0000_8000},
        '{32'h0005_4000, 32'h000A_0001, 32'h000E_FFFF},
        '{32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_FFFF},
        '{32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_0000}
    };

    lattice_cell_locator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d corner items outstanding",
                   cycle_count, corner_model.pending_corners.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: check each corner item, then pick the next ready value
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            seen_corner.node_addr    = m_tdata[24:0];
            seen_corner.frac[0]      = m_tdata[40:25];
            seen_corner.frac[1]      = m_tdata[56:41];
            seen_corner.frac[2]      = m_tdata[72:57];
            seen_corner.rest[0]      = m_tdata[89:73];
            seen_corner.rest[1]      = m_tdata[106:90];
            seen_corner.rest[2]      = m_tdata[123:107];
            seen_corner.corner       = m_tuser[2:0];
            seen_corner.out_of_range = m_tuser[3];
            seen_corner.last         = m_tlast;
            corner_model.check_corner(seen_corner);
        end
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (hold_request && !hold_done)
        begin
            // one long hold-off so the pipeline backs up into the input
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            m_tready  <= 1'b0;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode      <= rx_pattern_t'($urandom_range(0, 3));
                rx_mode_left <= $urandom_range(40, 200);
            end
            else
                rx_mode_left <= rx_mode_left - 1;
            rx_step <= (rx_step == 2) ? 0 : rx_step + 1;
            case (rx_mode)
                RX_STEADY:      m_tready <= 1'b1;
                RX_COIN:        m_tready <= $urandom_range(0, 1);
                RX_EVERY_THIRD: m_tready <= (rx_step == 0);
                default:        m_tready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // Offer one position; bursts of random length with random gaps between
    task automatic offer_position(input logic [POS_W-1:0] px, py, pz);
        s_tvalid <= 1'b1;
        s_tdata  <= {pz, py, px};
        do
            @(posedge clk);
        while (!s_tready);
        corner_model.note_position(px, py, pz);
        positions_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(0, 14);
        end
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        corner_model.write_register(index, value);
    endtask

    // Stop offering and wait until every corner item is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (corner_model.pending_corners.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Lattice settings per phase, extremes first, random ones last
    task automatic apply_setting(input int phase);
        logic [31:0] inv, ox, oy, oz, gx, gy, gz, hs;
        case (phase)
            0:
            begin
                inv = 32'd65536;   ox = '0; oy = '0; oz = '0;
                gx = 16; gy = 16; gz = 16; hs = 1;
            end
            1:
            begin
                inv = 32'hFFFF_FFFF; ox = 32'h7FFF_FFFF; oy = 32'h8000_0000; oz = '0;
                gx = 256; gy = 256; gz = 256; hs = 4;
            end
            2:
            begin
                inv = 32'd1; ox = 32'h8000_0000; oy = '0; oz = 32'h7FFF_FFFF;
                gx = 1; gy = 1; gz = 1; hs = 0;
            end
            3:
            begin
                inv = '0; ox = $urandom; oy = $urandom; oz = $urandom;
                gx = 0; gy = 0; gz = 0; hs = 5;
            end
            4:
            begin
                inv = $urandom_range(1 << 14, 1 << 19);
                ox = $urandom; oy = $urandom; oz = $urandom;
                gx = 511; gy = 300; gz = 257; hs = 7;
            end
            default:
            begin
                inv = $urandom_range(1 << 12, 1 << 20);
                ox = $urandom; oy = $urandom; oz = $urandom;
                gx = $urandom_range(1, 256); gy = $urandom_range(1, 256);
                gz = $urandom_range(1, 256); hs = $urandom_range(0, 4);
            end
        endcase
        write_reg(REG_INV_SPACING, inv);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_GRID_X, gx);
        write_reg(REG_GRID_Y, gy);
        write_reg(REG_GRID_Z, gz);
        write_reg(REG_HALO_SIZE, hs);
        cfg_we <= 1'b0;
    endtask

    // Random coordinate: mostly inside the local cells, some at the edges, some noise
    function automatic logic [POS_W-1:0] pick_coord(input int a);
        longint      span, target, delta;
        int          jitter;
        int unsigned roll;
        span   = (longint'(corner_model.effective_grid(a)) + 1) * longint'(ONE_Q16);
        roll   = $urandom_range(0, 99);
        jitter = $urandom_range(0, 6);
        jitter = jitter - 3;
        if (roll < 8 || corner_model.inv_spacing == '0)
            return $urandom;
        if (roll < 80)
            target = longint'($urandom_range(0, span - 1)) - longint'(HALF_Q16);
        else if (roll < 90)
            target = jitter - longint'(HALF_Q16);
        else
            target = span - longint'(HALF_Q16) + jitter;
        delta = (target * longint'(ONE_Q16)) / longint'({32'd0, corner_model.inv_spacing});
        return corner_model.origin[a] + delta[POS_W-1:0];
    endfunction

    // Stimulus
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < NUM_DIRECTED; i++)
            offer_position(directed_positions[i][0], directed_positions[i][1],
                           directed_positions[i][2]);
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_drained();
            apply_setting(phase);
            if (phase == HOLD_PHASE)
                hold_request <= 1'b1;
            repeat (ITEMS_PER_PHASE)
                offer_position(pick_coord(0), pick_coord(1), pick_coord(2));
        end
        wait_drained();
        $display("Sent %0d positions (%0d directed) over %0d lattice settings.",
                 positions_sent, NUM_DIRECTED, NUM_PHASES + 1);
        $display("Checked %0d corner items, %0d flagged out of range; %0d mismatches.",
                 corner_model.checked, corner_model.flagged, corner_model.failures);
        if (corner_model.failures == 0 && corner_model.pending_corners.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
